// ----- hw/rtl/mpq_pkg.sv -----
// Shared types and codes for the max-priority queue core.
// Used by mpq_cell, max_priority_queue_core and the testbench; depends on nothing.
`default_nettype none

package mpq_pkg;

	localparam int unsigned ENTRY_W = 32;
	localparam int unsigned COUNT_W = 5;

	typedef enum logic {
		KIND_INSERT  = 1'b0,
		KIND_DEQUEUE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// broadcast from the queue control to every cell
	typedef struct packed {
		logic                       ins_en;
		logic                       deq_en;
		logic signed [ENTRY_W-1:0]  value;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mpq_cell.sv -----
// One slot of the sorted store: holds one entry, compares it with the
// broadcast value and shifts with its neighbors. Depends on mpq_pkg.
`default_nettype none

module mpq_cell (
	input  wire logic                              clk,
	input  wire mpq_pkg::cell_cmd_t                cmd,
	input  wire logic                              occ,         // slot holds a live entry
	input  wire logic                              left_keep,   // upper neighbor keeps its entry
	input  wire logic signed [mpq_pkg::ENTRY_W-1:0] left_entry,
	input  wire logic signed [mpq_pkg::ENTRY_W-1:0] right_entry,
	output logic signed [mpq_pkg::ENTRY_W-1:0]      entry,
	output logic                                    keep
);
	import mpq_pkg::*;

	logic signed [ENTRY_W-1:0] entry_q;

	// equal values stay ahead of the new one
	assign keep  = occ && (entry_q >= cmd.value);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (!keep) begin
				entry_q <= left_keep ? cmd.value : left_entry;
			end
		end else if (cmd.deq_en) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/max_priority_queue_core.sv -----
// Bounded max-priority queue core: a row of mpq_cell slots kept in
// descending order, plus count, result register and stream handshake.
// Depends on mpq_pkg and mpq_cell.
//
//  channel | dir | tdata                        | tuser
//  --------+-----+------------------------------+-----------------------
//  s_*     | in  | [31:0] value                 | [0] kind (0 ins, 1 deq)
//  m_*     | out | [31:0] max_value,[36:32] cnt | [1:0] status
//
// One item per cycle while s_tready is high: every slot decides locally whether
// to keep its entry, take the new value or take a neighbor's entry.
// The result register is loaded on the same edge the input transfer occurs.
// s_tready drops only while a result waits and m_tready is low.
// arst_n clears the count and the result valid flag; slot contents are
// not reset and are only read below the count.
`default_nettype none

module max_priority_queue_core #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	input  wire logic [0:0]  s_tuser,   // [0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] max_value, [36:32] count, rest zero
	output logic [1:0]       m_tuser    // [1:0] status
);
	import mpq_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              cnt_next;
	logic [CW+COUNT_W-1:0]      cnt_wide;
	logic                       xfer_in;
	logic                       is_deq;
	logic                       full;
	logic                       empty;
	cell_cmd_t                  cmd;
	status_t                    status;
	logic signed [ENTRY_W-1:0]  res_value;

	logic signed [ENTRY_W-1:0]  entry [CAPACITY];
	logic                       keep  [CAPACITY];

	logic                       out_valid_q;
	logic signed [ENTRY_W-1:0]  out_value_q;
	logic [COUNT_W-1:0]         out_count_q;
	status_t                    out_status_q;

	assign xfer_in  = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;
	assign is_deq   = (kind_t'(s_tuser[0]) == KIND_DEQUEUE);
	assign full     = (cnt_q == CW'(CAPACITY));
	assign empty    = (cnt_q == '0);

	assign cmd.ins_en = xfer_in && !is_deq && !full;
	assign cmd.deq_en = xfer_in && is_deq && !empty;
	assign cmd.value  = s_tdata;

	// status, removed value and new count for this transfer
	always_comb begin
		status    = ST_OK;
		res_value = '0;
		cnt_next  = cnt_q;
		if (is_deq) begin
			if (empty) begin
				status = ST_EMPTY;
			end else begin
				res_value = entry[0];
				cnt_next  = cnt_q - CW'(1);
			end
		end else begin
			if (full) begin
				status = ST_FULL;
			end else begin
				cnt_next = cnt_q + CW'(1);
			end
		end
	end

	// count field is the low bits of the count after this transfer
	assign cnt_wide = (CW + COUNT_W)'(cnt_next);

	// slot row: index 0 holds the maximum
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                      lkeep;
		logic signed [ENTRY_W-1:0] lentry;
		logic signed [ENTRY_W-1:0] rentry;

		if (i == 0) begin : g_head
			assign lkeep  = 1'b1;
			assign lentry = cmd.value;
		end else begin : g_body
			assign lkeep  = keep[i-1];
			assign lentry = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rentry = '0;
		end else begin : g_mid
			assign rentry = entry[i+1];
		end

		mpq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occ         (cnt_q > CW'(i)),
			.left_keep   (lkeep),
			.left_entry  (lentry),
			.right_entry (rentry),
			.entry       (entry[i]),
			.keep        (keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (xfer_in) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer_in) begin
			out_value_q  <= res_value;
			out_count_q  <= cnt_wide[COUNT_W-1:0];
			out_status_q <= status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_count_q, out_value_q};
	assign m_tuser  = out_status_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("held count above capacity");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not grow the count");

	a_deq_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deq_en |=> cnt_q == $past(cnt_q) - CW'(1))
		else $error("dequeue did not shrink the count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> m_tdata[31:0] == '0)
		else $error("failed transfer carries a nonzero value");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/mpq_result_checker.sv -----
// Result checker for max_priority_queue_core: tracks a sorted copy of the queue
// from input transfers and compares each output transfer against it.
// Depends on mpq_pkg.
`timescale 1ns / 100ps

module mpq_result_checker
	import mpq_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	input  wire logic [0:0]  s_tuser,   // [0] kind
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [39:0] m_tdata,   // [31:0] max_value, [36:32] count, [39:37] zero
	input  wire logic [1:0]  m_tuser,   // [1:0] status
	output int               fail_count,
	output int               pending_results,
	output int               results_checked,
	output int               full_drops,
	output int               empty_pops
);

	typedef struct packed {
		logic signed [ENTRY_W-1:0] max_value;
		status_t                   status;
		logic [COUNT_W-1:0]        count;
	} queue_result_t;

	logic signed [ENTRY_W-1:0] held_vals [CAPACITY];
	int                        held_n;
	queue_result_t             awaited_results [$];
	int                        errs, n_checked, n_full, n_empty;

	// one step of the queue: sorted insert (equal values stay behind older ones)
	// or removal of the head
	function automatic queue_result_t apply_queue_op(kind_t kind,
			logic signed [ENTRY_W-1:0] value);
		queue_result_t r;
		int pos;
		r.max_value = '0;
		r.status    = ST_OK;
		if (kind == KIND_INSERT) begin
			if (held_n >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_n && held_vals[pos] >= value)
					pos++;
				for (int i = held_n; i > pos; i--)
					held_vals[i] = held_vals[i-1];
				held_vals[pos] = value;
				held_n++;
			end
		end else begin
			if (held_n == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.max_value = held_vals[0];
				for (int i = 0; i + 1 < held_n; i++)
					held_vals[i] = held_vals[i+1];
				held_n--;
			end
		end
		r.count = held_n[COUNT_W-1:0];
		return r;
	endfunction

	task automatic flag_field(string field, logic [39:0] want, logic [39:0] got);
		$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
		errs++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		queue_result_t want;
		if (!arst_n) begin
			awaited_results.delete();
			held_n = 0;
			errs = 0;
			n_checked = 0;
			n_full = 0;
			n_empty = 0;
		end else begin
			// output side first: a result never leaves on its own input's edge
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, actual tdata 0x%0h tuser 0x%0h",
						$time, m_tdata, m_tuser);
					errs++;
				end else begin
					want = awaited_results.pop_front();
					n_checked++;
					if (m_tdata[31:0] !== want.max_value)
						flag_field("max_value", {8'h00, want.max_value},
							{8'h00, m_tdata[31:0]});
					if (m_tdata[36:32] !== want.count)
						flag_field("count", {35'h0, want.count}, {35'h0, m_tdata[36:32]});
					if (m_tdata[39:37] !== 3'b000)
						flag_field("tdata pad", '0, {37'h0, m_tdata[39:37]});
					if (m_tuser !== want.status)
						flag_field("status", {38'h0, want.status}, {38'h0, m_tuser});
				end
			end
			if (s_tvalid && s_tready) begin
				want = apply_queue_op(kind_t'(s_tuser[0]), s_tdata);
				if (want.status == ST_FULL)
					n_full++;
				if (want.status == ST_EMPTY)
					n_empty++;
				awaited_results.push_back(want);
			end
		end
		fail_count      <= errs;
		pending_results <= awaited_results.size();
		results_checked <= n_checked;
		full_drops      <= n_full;
		empty_pops      <= n_empty;
	end

endmodule

// ----- tb/sv/tb_max_priority_queue_core.sv -----
// Testbench top for max_priority_queue_core: drives bursty insert/dequeue
// traffic with a stalling receiver and reports the verdict.
// Depends on mpq_pkg, max_priority_queue_core and mpq_result_checker.
`timescale 1ns / 100ps

module tb_max_priority_queue_core;
	import mpq_pkg::*;

	localparam int unsigned CAPACITY     = 16;
	localparam int          RANDOM_ITEMS = 1650;
	localparam int          HOLD_CYCLES  = 300;     // long receiver hold-off
	localparam int          CYCLE_LIMIT  = 250000;  // slowest legal run is far below this
	localparam int          DRAIN_CYCLES = 8;

	// value flavors for the random part
	typedef enum int {
		VAL_WIDE,    // any 32-bit pattern
		VAL_NARROW,  // tight range around zero, lots of equal values
		VAL_EDGE     // near the signed limits, plus -1 and zero
	} val_style_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] value
	logic [0:0]  s_tuser;   // [0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] max_value, [36:32] count, [39:37] zero
	logic [1:0]  m_tuser;   // [1:0] status

	int fail_count, pending_results, results_checked, full_drops, empty_pops;
	int items_sent;
	int burst_left;
	bit quiet_mode;         // no sender gaps while set

	max_priority_queue_core #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	mpq_result_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.fail_count     (fail_count),
		.pending_results(pending_results),
		.results_checked(results_checked),
		.full_drops     (full_drops),
		.empty_pops     (empty_pops)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One transfer on the input channel. tvalid stays high across a burst;
	// when the burst runs out it drops for a random gap (unless quiet_mode),
	// with junk on the data lines meanwhile.
	task automatic push_item(input kind_t kind, input logic [31:0] value);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = quiet_mode ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) begin
					s_tdata <= $urandom();
					s_tuser <= 1'($urandom_range(0, 1));
					@(posedge clk);
				end
			end
		end
	endtask

	function automatic logic [31:0] pick_value(input val_style_t style);
		logic [31:0] v;
		case (style)
			VAL_NARROW: v = $urandom_range(0, 15) - 8;
			VAL_EDGE: begin
				case ($urandom_range(0, 5))
					0: v = 32'h8000_0000;
					1: v = 32'h8000_0001;
					2: v = 32'h7fff_ffff;
					3: v = 32'h7fff_fffe;
					4: v = 32'hffff_ffff;
					default: v = 32'h0000_0000;
				endcase
			end
			default: v = $urandom();
		endcase
		return v;
	endfunction

	// Receiver: segments of random ready density, including full-rate ones,
	// plus one long hold-off so the result register backs up into s_tready.
	initial begin : rx_ready
		int seg, pct, cyc, hold_at;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		hold_at = $urandom_range(600, 1200);
		cyc = 0;
		forever begin
			seg = $urandom_range(20, 120);
			case ($urandom_range(0, 3))
				0: pct = 100;
				1: pct = 70;
				2: pct = 40;
				default: pct = 15;
			endcase
			repeat (seg) begin
				@(posedge clk);
				cyc++;
				if (cyc == hold_at) begin
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end else begin
					m_tready <= ($urandom_range(1, 100) <= pct);
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: run timed out with %0d results outstanding", $time, pending_results);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int seg_len, ins_pct, rand_sent, drain;
		val_style_t style;
		kind_t kind;

		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= '0;
		items_sent = 0;
		burst_left = 4;
		quiet_mode = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, fill to capacity with limits and duplicates,
		// insert into a full queue, then a few pops
		push_item(KIND_DEQUEUE, 32'hffff_ffff);
		push_item(KIND_INSERT, 32'h7fff_ffff);
		push_item(KIND_INSERT, 32'h8000_0000);
		push_item(KIND_INSERT, 32'h0000_0000);
		push_item(KIND_INSERT, 32'hffff_ffff);
		push_item(KIND_INSERT, 32'h0000_0001);
		push_item(KIND_INSERT, 32'd5);
		push_item(KIND_INSERT, 32'd5);
		push_item(KIND_INSERT, -32'sd5);
		push_item(KIND_INSERT, 32'h8000_0000);
		push_item(KIND_INSERT, 32'h7fff_ffff);
		push_item(KIND_INSERT, 32'h8000_0001);
		push_item(KIND_INSERT, 32'h7fff_fffe);
		push_item(KIND_INSERT, 32'd100);
		push_item(KIND_INSERT, -32'sd100);
		push_item(KIND_INSERT, 32'd5);
		push_item(KIND_INSERT, 32'haaaa_5555);
		push_item(KIND_INSERT, 32'd7);          // full: dropped
		push_item(KIND_DEQUEUE, 32'h0000_0000);
		push_item(KIND_DEQUEUE, 32'h5555_aaaa);
		push_item(KIND_DEQUEUE, $urandom());
		push_item(KIND_DEQUEUE, $urandom());

		// random: segments biased toward inserts or dequeues so the fill level
		// sweeps between empty and full again and again
		rand_sent = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			seg_len = $urandom_range(10, 60);
			case ($urandom_range(0, 2))
				0: ins_pct = 20;
				1: ins_pct = 50;
				default: ins_pct = 85;
			endcase
			quiet_mode = ($urandom_range(0, 4) == 0);
			repeat (seg_len) begin
				kind = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_DEQUEUE;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: style = VAL_WIDE;
					5, 6, 7:       style = VAL_NARROW;
					default:       style = VAL_EDGE;
				endcase
				push_item(kind, pick_value(style));
				rand_sent++;
			end
		end

		// let the checker book the last transfer before polling pending_results
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		drain = DRAIN_CYCLES;
		repeat (drain) @(posedge clk);

		$display("Run covered %0d queue operations, %0d results checked:", items_sent,
			results_checked);
		$display("  %0d inserts refused at capacity, %0d dequeues on an empty queue",
			full_drops, empty_pops);
		if (fail_count == 0 && pending_results == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_cell.sv
hw/rtl/max_priority_queue_core.sv
tb/sv/mpq_result_checker.sv
tb/sv/tb_max_priority_queue_core.sv
